// ----- rtl/sbt_pkg.sv -----
// Shared types and constants for the source byte tokenizer.
// Token kinds, character codes, the token and token-group records, queue sizing.
// No dependencies.
package sbt_pkg;

   localparam int unsigned POS_BITS_DEF = 24;
   localparam int unsigned OUT_BITS     = 24;
   localparam int unsigned KIND_BITS    = 5;
   localparam int unsigned GROUP_MAX    = 3;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_BITS    = $clog2(QUEUE_DEPTH);

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_COMMA    = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_DOT      = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_MINUS    = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_PLUS     = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_SEMI     = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_STAR     = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_NOT      = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_EQ       = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_LT       = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_GT       = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_SLASH    = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_STRING   = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_EOF      = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_BADCHAR  = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_OPENSTR  = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_LAST     = KIND_OPENSTR;

   // characters with a role of their own
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [OUT_BITS-1:0]  start;
      logic [OUT_BITS-1:0]  len;
      logic [OUT_BITS-1:0]  line;
   } token_type;

   // tokens caused by one input item, in order
   typedef struct packed {
      logic [1:0]                 count;
      token_type [GROUP_MAX-1:0]  tok;
   } group_type;

endpackage

// ----- rtl/sbt_scan.sv -----
// Front end of the tokenizer: accepts bytes, runs the scan state machine and
// builds the group of tokens each item causes. Depends on sbt_pkg.
module sbt_scan #(
   parameter int unsigned POS_BITS = sbt_pkg::POS_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_op,
   input  logic [7:0]         req_ch,
   output logic               req_ready,
   input  logic               grp_ready,
   output logic               grp_valid,
   output sbt_pkg::group_type grp
);
   import sbt_pkg::*;

   typedef enum logic [3:0] {
      MODE_NORMAL,
      MODE_NOT,
      MODE_EQ,
      MODE_LT,
      MODE_GT,
      MODE_COMMENT,
      MODE_STRING,
      MODE_INT,
      MODE_INTDOT,
      MODE_FRAC
   } mode_type;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   mode_type            mode_ff, mode_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] line_ff, line_in;

   logic                accept;
   logic                is_digit;
   logic [KIND_BITS-1:0] pend_kind;
   logic [POS_BITS:0]   pos_x, start_p1, str_diff;
   logic [POS_BITS-1:0] span_str, span_num, span_dot, dot_pos;

   mode_type            nrm_mode;
   logic                nrm_emit;
   logic [KIND_BITS-1:0] nrm_kind;
   logic                nrm_bump;

   group_type           grp_v;
   logic [1:0]          n_v;
   logic                do_normal;
   logic                bump;

   function automatic token_type mk(input logic [KIND_BITS-1:0] kind,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [POS_BITS-1:0] len,
                                    input logic [POS_BITS-1:0] line);
      token_type t;
      t.kind  = kind;
      t.start = OUT_BITS'(start);
      t.len   = OUT_BITS'(len);
      t.line  = OUT_BITS'(line);
      return t;
   endfunction

   assign accept    = req_valid & grp_ready;
   assign req_ready = grp_ready;
   assign is_digit  = (req_ch >= "0") && (req_ch <= "9");

   // string content length excludes the opening quote
   assign pos_x    = {1'b0, pos_ff};
   assign start_p1 = {1'b0, start_ff} + (POS_BITS+1)'(1);
   assign str_diff = pos_x - start_p1;
   assign span_str = (pos_x > start_p1) ? str_diff[POS_BITS-1:0] : '0;
   assign span_num = (pos_ff > start_ff) ? pos_ff - start_ff : '0;
   assign span_dot = (pos_ff > start_ff) ? span_num - POS_BITS'(1) : '0;
   assign dot_pos  = (pos_ff > start_ff) ? pos_ff - POS_BITS'(1) : start_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_NOT: pend_kind = KIND_NOT;
         MODE_EQ:  pend_kind = KIND_EQ;
         MODE_LT:  pend_kind = KIND_LT;
         default:  pend_kind = KIND_GT;
      endcase
   end

   // classify a byte seen in normal mode
   always_comb begin
      nrm_mode = MODE_NORMAL;
      nrm_emit = 1'b1;
      nrm_kind = KIND_BADCHAR;
      nrm_bump = 1'b0;
      unique case (req_ch)
         "(":      nrm_kind = KIND_LPAREN;
         ")":      nrm_kind = KIND_RPAREN;
         "{":      nrm_kind = KIND_LBRACE;
         "}":      nrm_kind = KIND_RBRACE;
         ",":      nrm_kind = KIND_COMMA;
         CH_DOT:   nrm_kind = KIND_DOT;
         "-":      nrm_kind = KIND_MINUS;
         "+":      nrm_kind = KIND_PLUS;
         ";":      nrm_kind = KIND_SEMI;
         "*":      nrm_kind = KIND_STAR;
         "/":      nrm_kind = KIND_SLASH;
         "!": begin
            nrm_mode = MODE_NOT;
            nrm_emit = 1'b0;
         end
         CH_EQ: begin
            nrm_mode = MODE_EQ;
            nrm_emit = 1'b0;
         end
         "<": begin
            nrm_mode = MODE_LT;
            nrm_emit = 1'b0;
         end
         ">": begin
            nrm_mode = MODE_GT;
            nrm_emit = 1'b0;
         end
         CH_HASH: begin
            nrm_mode = MODE_COMMENT;
            nrm_emit = 1'b0;
         end
         CH_QUOTE: begin
            nrm_mode = MODE_STRING;
            nrm_emit = 1'b0;
         end
         " ", 8'h0D, 8'h09: nrm_emit = 1'b0;
         CH_NL: begin
            nrm_emit = 1'b0;
            nrm_bump = 1'b1;
         end
         default: begin
            if (is_digit) begin
               nrm_mode = MODE_INT;
               nrm_emit = 1'b0;
            end
         end
      endcase
   end

   always_comb begin
      grp_v     = '0;
      n_v       = 2'd0;
      do_normal = 1'b0;
      bump      = 1'b0;
      mode_in   = mode_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      if (req_op) begin
         unique case (mode_ff)
            MODE_NOT, MODE_EQ, MODE_LT, MODE_GT: begin
               grp_v.tok[n_v] = mk(pend_kind, start_ff, POS_BITS'(1), line_ff);
               n_v = n_v + 2'd1;
            end
            MODE_STRING: begin
               grp_v.tok[n_v] = mk(KIND_OPENSTR, start_ff, span_str, line_ff);
               n_v = n_v + 2'd1;
            end
            MODE_INT, MODE_FRAC: begin
               grp_v.tok[n_v] = mk(KIND_NUMBER, start_ff, span_num, line_ff);
               n_v = n_v + 2'd1;
            end
            MODE_INTDOT: begin
               grp_v.tok[n_v] = mk(KIND_NUMBER, start_ff, span_dot, line_ff);
               n_v = n_v + 2'd1;
               grp_v.tok[n_v] = mk(KIND_DOT, dot_pos, POS_BITS'(1), line_ff);
               n_v = n_v + 2'd1;
            end
            default: ;
         endcase
         grp_v.tok[n_v] = mk(KIND_EOF, pos_ff, '0, line_ff);
         n_v = n_v + 2'd1;
         mode_in = MODE_NORMAL;
      end else begin
         unique case (mode_ff)
            MODE_NOT, MODE_EQ, MODE_LT, MODE_GT: begin
               if (req_ch == CH_EQ) begin
                  grp_v.tok[n_v] = mk(pend_kind + KIND_BITS'(1), start_ff,
                                      POS_BITS'(2), line_ff);
                  n_v = n_v + 2'd1;
                  mode_in = MODE_NORMAL;
               end else begin
                  grp_v.tok[n_v] = mk(pend_kind, start_ff, POS_BITS'(1), line_ff);
                  n_v = n_v + 2'd1;
                  do_normal = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (req_ch == CH_NL) begin
                  bump    = 1'b1;
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_STRING: begin
               if (req_ch == CH_QUOTE) begin
                  grp_v.tok[n_v] = mk(KIND_STRING, start_ff, span_str, line_ff);
                  n_v = n_v + 2'd1;
                  mode_in = MODE_NORMAL;
               end else if (req_ch == CH_NL) begin
                  bump = 1'b1;
               end
            end
            MODE_INT: begin
               if (req_ch == CH_DOT) begin
                  mode_in = MODE_INTDOT;
               end else if (!is_digit) begin
                  grp_v.tok[n_v] = mk(KIND_NUMBER, start_ff, span_num, line_ff);
                  n_v = n_v + 2'd1;
                  do_normal = 1'b1;
               end
            end
            MODE_INTDOT: begin
               if (is_digit) begin
                  mode_in = MODE_FRAC;
               end else begin
                  // number, then the held dot, then this byte afresh
                  grp_v.tok[n_v] = mk(KIND_NUMBER, start_ff, span_dot, line_ff);
                  n_v = n_v + 2'd1;
                  grp_v.tok[n_v] = mk(KIND_DOT, dot_pos, POS_BITS'(1), line_ff);
                  n_v = n_v + 2'd1;
                  do_normal = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_digit) begin
                  grp_v.tok[n_v] = mk(KIND_NUMBER, start_ff, span_num, line_ff);
                  n_v = n_v + 2'd1;
                  do_normal = 1'b1;
               end
            end
            default: do_normal = 1'b1;
         endcase
         if (do_normal) begin
            start_in = pos_ff;
            mode_in  = nrm_mode;
            bump     = nrm_bump;
            if (nrm_emit) begin
               grp_v.tok[n_v] = mk(nrm_kind, pos_ff, POS_BITS'(1), line_ff);
               n_v = n_v + 2'd1;
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_BITS'(1);
         end
      end
      line_in = (bump && (line_ff != POS_MAX)) ? line_ff + POS_BITS'(1) : line_ff;
      grp_v.count = n_v;
   end

   assign grp       = grp_v;
   assign grp_valid = accept && (n_v != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= POS_BITS'(1);
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
      end
   end

endmodule

// ----- rtl/sbt_queue.sv -----
// Short queue of token groups between the scanner and the token output stage.
// Depends on sbt_pkg.
module sbt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sbt_pkg::group_type push_grp,
   output logic               push_ready,
   output logic               head_valid,
   output sbt_pkg::group_type head_grp,
   input  logic               pop
);
   import sbt_pkg::*;

   group_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]    count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] wrap_inc(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   assign push_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_grp   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_grp;
      end
   end

endmodule

// ----- rtl/sbt_emit.sv -----
// Back end of the tokenizer: walks the head token group one token a cycle
// into the registered result stream, unless stalled. Depends on sbt_pkg.
module sbt_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  sbt_pkg::group_type head_grp,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [71:0]        rsp_tdata,
   output logic [4:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import sbt_pkg::*;

   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   token_type           tok_ff;
   logic                last_ff;
   token_type           cur;
   logic                load;
   logic                is_last;

   assign load    = head_valid && (!valid_ff || rsp_tready);
   assign cur     = head_grp.tok[idx_ff];
   assign is_last = (idx_ff == (head_grp.count - 2'd1));
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= cur;
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = tok_ff.kind;
   assign rsp_tdata  = {tok_ff.line, tok_ff.len, tok_ff.start};
   assign rsp_tlast  = last_ff;

endmodule

// ----- rtl/source_byte_tokenizer.sv -----
// Source byte tokenizer: one byte or end marker per item in, tokens out.
// Throughput: one item per cycle while the 4-group queue has room; tokens
// leave at one per cycle while rsp_tready allows, so an item causing two or
// three tokens holds the output for each of them in turn. The first token
// of an item is written to the queue, then loaded into the output register.
// Reset (synchronous): normal mode, offsets zero, line one, queue empty.
module source_byte_tokenizer #(
   parameter int unsigned POS_BITS = sbt_pkg::POS_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] op: 0 byte, 1 end of input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [23:0] start_offset, [47:24] token_length,
                                    // [71:48] line_number
   output logic [4:0]  rsp_tuser,   // [4:0] kind
   output logic        rsp_tlast
);
   import sbt_pkg::*;

   logic      grp_valid;
   logic      grp_ready;
   group_type grp;
   logic      head_valid;
   group_type head_grp;
   logic      pop;

   sbt_scan #(.POS_BITS(POS_BITS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ch    (req_tdata),
      .req_ready (req_tready),
      .grp_ready (grp_ready),
      .grp_valid (grp_valid),
      .grp       (grp)
   );

   sbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_valid),
      .push_grp   (grp),
      .push_ready (grp_ready),
      .head_valid (head_valid),
      .head_grp   (head_grp),
      .pop        (pop)
   );

   sbt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_grp   (head_grp),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/sbt_checker.sv -----
// Port-level checks for the source byte tokenizer, bound to the top level.
// Depends on sbt_pkg.
module sbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [4:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import sbt_pkg::*;

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= KIND_LAST))
      else $error("token kind out of range");

   // end of input always closes its run of results
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_EOF)) |-> rsp_tlast)
      else $error("EOF token not marked last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (.*);
